@@ rtl/core/ccw_pkg.sv @@
// shared constants, types and helpers for the coin change ways counter
package ccw_pkg;

  localparam int MAX_AMOUNT = 4096;
  localparam int DEPTH      = MAX_AMOUNT + 1;
  localparam int AW         = $clog2(DEPTH);
  localparam int TGT_W      = 13;
  localparam int COIN_W     = 16;
  localparam int WAYS_W     = 32;

  localparam logic [AW-1:0] MAX_ADDR = AW'(MAX_AMOUNT);

  typedef struct packed {
    logic          issue;   // update read at addr and addr_b, write back next cycle
    logic          clr;     // clear write at addr
    logic [AW-1:0] addr;
    logic [AW-1:0] addr_b;
  } tbl_ctrl_t;

  // target saturates at MAX_AMOUNT, the last table address
  function automatic logic [AW-1:0] eff_target(input logic [TGT_W-1:0] tgt);
    logic [AW-1:0] res;
    if (32'(tgt) > MAX_AMOUNT) res = MAX_ADDR;
    else                       res = AW'(tgt);
    return res;
  endfunction

endpackage

@@ rtl/core/ccw_table.sv @@
// ways table memory with the shared 32-bit accumulate adder
module ccw_table import ccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tbl_ctrl_t         ctrl,
  output logic [WAYS_W-1:0] rd_data
);

  logic [WAYS_W-1:0] mem_r [DEPTH];
  logic [WAYS_W-1:0] rdata_a_r;
  logic [WAYS_W-1:0] rdata_b_r;
  logic [WAYS_W-1:0] last_wdata_r;
  logic [AW-1:0]     wr_addr_r;
  logic              wr_v_r;
  logic              fwd_r;
  logic [WAYS_W-1:0] addend;
  logic [WAYS_W-1:0] sum;

  // the entry at addr_b may be the one being written back in the read cycle
  assign addend  = fwd_r ? last_wdata_r : rdata_b_r;
  assign sum     = rdata_a_r + addend;
  assign rd_data = rdata_a_r;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      mem_r[ctrl.addr] <= (ctrl.addr == '0) ? WAYS_W'(1) : '0;
    end else if (wr_v_r) begin
      mem_r[wr_addr_r] <= sum;
    end
    rdata_a_r <= mem_r[ctrl.addr];
    rdata_b_r <= mem_r[ctrl.addr_b];
    wr_addr_r <= ctrl.addr;
    if (wr_v_r) begin
      last_wdata_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      wr_v_r <= ctrl.issue;
      fwd_r  <= ctrl.issue && wr_v_r && (wr_addr_r == ctrl.addr_b);
    end
  end

endmodule

@@ rtl/core/ccw_seq.sv @@
// sequencer: walks the table per coin, reads the result, clears the table
module ccw_seq import ccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TGT_W-1:0]  target_amount,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COIN_W-1:0] in_coin_value,
  input  logic              in_last_coin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAYS_W-1:0] out_ways,
  output tbl_ctrl_t         ctrl,
  input  logic [WAYS_W-1:0] rd_data
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_RUN    = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_READ   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     a_r, a_nxt;
  logic [AW-1:0]     t_r, t_nxt;
  logic [AW-1:0]     coin_r, coin_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WAYS_W-1:0] out_ways_r, out_ways_nxt;
  logic [AW-1:0]     t_in;
  logic              coin_ok;

  assign t_in    = eff_target(target_amount);
  assign coin_ok = (in_coin_value != '0) && (32'(in_coin_value) <= 32'(t_in));

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    t_nxt         = t_r;
    coin_nxt      = coin_r;
    last_nxt      = last_r;
    out_ways_nxt  = out_ways_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    ctrl.issue    = 1'b0;
    ctrl.clr      = 1'b0;
    ctrl.addr     = a_r;
    ctrl.addr_b   = a_r - coin_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        ctrl.clr = 1'b1;
        if (a_r == MAX_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          a_nxt = a_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          t_nxt    = t_in;
          last_nxt = in_last_coin;
          if (coin_ok) begin
            coin_nxt  = AW'(in_coin_value);
            a_nxt     = AW'(in_coin_value);
            state_nxt = S_RUN;
          end else if (in_last_coin) begin
            state_nxt = S_READ;
          end
        end
      end
      S_RUN: begin
        ctrl.issue = 1'b1;
        if (a_r == t_r) begin
          state_nxt = S_DRAIN;
        end else begin
          a_nxt = a_r + AW'(1);
        end
      end
      S_DRAIN: begin
        // final write-back lands in this cycle
        state_nxt = last_r ? S_READ : S_IDLE;
      end
      S_READ: begin
        ctrl.addr = t_r;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        ctrl.addr = t_r;
        if (!out_valid_r || out_ready) begin
          out_ways_nxt  = rd_data;
          out_valid_nxt = 1'b1;
          a_nxt         = '0;
          state_nxt     = S_CLEAR;
        end
      end
      default: begin
        a_nxt     = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      a_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    coin_r     <= coin_nxt;
    last_r     <= last_nxt;
    out_ways_r <= out_ways_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;

  a_no_clear_during_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.issue && ctrl.clr))
    else $error("clear write collides with table update");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (a_r <= t_r && a_r >= coin_r && coin_r != '0))
    else $error("table walk outside coin..target");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result raised outside result state");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && (!out_valid_r || out_ready)) |=>
      (state_r == S_CLEAR && a_r == '0))
    else $error("table not cleared after result");

endmodule

@@ rtl/core/coin_change_ways_count.sv @@
// top level: coin change ways counter over a 4097-entry ways table
// a coin c against effective target t walks table entries c..t, then drains;
//   a zero coin or one above the target is skipped without a walk
// the table walk does one entry per cycle through a single shared 32-bit adder
// a last coin then reads the result at the target, then runs a clearing pass over all 4097 entries
// reset (synchronous, rst_n low) starts the same clearing pass;
//   no transfer is accepted during it, target register resets to 0
module coin_change_ways_count import ccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COIN_W-1:0] in_coin_value,
  input  logic              in_last_coin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAYS_W-1:0] out_ways,
  input  logic              cfg_we,
  input  logic [TGT_W-1:0]  cfg_wdata
);

  logic [TGT_W-1:0]  target_r;
  tbl_ctrl_t         ctrl;
  logic [WAYS_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  ccw_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .target_amount (target_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coin_value (in_coin_value),
    .in_last_coin  (in_last_coin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ways      (out_ways),
    .ctrl          (ctrl),
    .rd_data       (rd_data)
  );

  ccw_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_data (rd_data)
  );

endmodule
